// ===== src/assert_macros.svh =====
// Assertion macros, used by abs_pct_error_statistics_top.
// Clocked on clk; APES_ASSERT is disabled while rst_n is low, APES_ASSERT_ALWAYS is not. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define APES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define APES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APES_ASSERT(lbl, prop, msg)
`define APES_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/apes_pkg.sv =====
// Package for the error-statistics monitor: field widths, limits,
// sequencer states and divider operation codes. No dependencies.
package apes_pkg;

  localparam int VAL_W     = 18;
  localparam int PCT_W     = 32;
  localparam int TRIALS_W  = 32;
  localparam int ABS_SUM_W = 50;
  localparam int PCT_SUM_W = 64;
  localparam int DVD_W     = 64;

  localparam int QW_PCT    = 31;
  localparam int QW_ABS    = 18;
  localparam int QCNT_W    = 5;

  localparam logic [PCT_W-1:0] RATIO_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_POST,
    S_STATS,
    S_PSUM,
    S_DONE
  } apes_state_t;

  typedef enum logic [1:0] {
    OP_RATIO,
    OP_MABS,
    OP_MPCT
  } apes_op_t;

endpackage

// ===== src/apes_if.sv =====
// Item channels of the error-statistics monitor: request in, statistics out.
// Depends on apes_pkg.
interface apes_in_if import apes_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [VAL_W-1:0] correct_value;
  logic signed [VAL_W-1:0] measured_value;

  modport source (output valid, req_type, correct_value, measured_value, input ready);
  modport sink   (input valid, req_type, correct_value, measured_value, output ready);
endinterface

interface apes_out_if import apes_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TRIALS_W-1:0]     trials;
  logic [VAL_W-1:0]        mean_abs_err;
  logic [VAL_W-1:0]        max_abs_err;
  logic [VAL_W-1:0]        min_abs_err;
  logic signed [PCT_W-1:0] mean_pct_err;
  logic signed [PCT_W-1:0] max_pct_err;
  logic signed [PCT_W-1:0] min_pct_err;
  logic                    zero_ref;

  modport source (output valid, trials, mean_abs_err, max_abs_err, min_abs_err,
                  mean_pct_err, max_pct_err, min_pct_err, zero_ref, input ready);
  modport sink   (input valid, trials, mean_abs_err, max_abs_err, min_abs_err,
                  mean_pct_err, max_pct_err, min_pct_err, zero_ref, output ready);
endinterface

// ===== src/abs_pct_error_statistics_top.sv =====
// Error-statistics monitor top level. Depends on apes_pkg, apes_if, assert_macros.svh.
// Update item: three divisions on one shared restoring divider (one quotient bit per cycle;
//   quotients of 31, 18 and 31 bits). A zero reference skips the ratio division; a division
//   whose quotient would saturate skips its steps. A clear skips the divisions and goes
//   straight to the result.
// One item in flight; the next item is accepted while the result waits in the output register.
// Reset (rst_n, synchronous, active low) zeroes all statistics and empties the output.
`include "assert_macros.svh"

module abs_pct_error_statistics_top
  import apes_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  apes_in_if.sink    in_ch,
  apes_out_if.source out_ch
);

  localparam int DVR_W = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
  localparam int RW    = DVR_W + 1;
  localparam int TRW   = (COUNT_BITS > TRIALS_W) ? COUNT_BITS : TRIALS_W + 1;

  apes_state_t state_r, state_nxt;

  // control
  logic in_ready;
  logic in_acc;
  logic out_load;

  // datapath registers
  apes_op_t                 op_r;
  logic [VAL_W-1:0]         err_r;
  logic [VAL_W-1:0]         den_r;
  logic                     neg_r;
  logic                     zref_r;
  logic signed [PCT_W-1:0]  pct_r;
  logic [QCNT_W-1:0]        cnt_r;
  logic [RW-1:0]            rem_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [QW_PCT-1:0]        q_r;
  logic                     sum_en_r;

  // statistics
  logic [COUNT_BITS-1:0]       count_r;
  logic [ABS_SUM_W-1:0]        abs_sum_r;
  logic signed [PCT_SUM_W-1:0] pct_sum_r;
  logic [VAL_W-1:0]            abs_max_r, abs_min_r;
  logic signed [PCT_W-1:0]     pct_max_r, pct_min_r;
  logic [VAL_W-1:0]            mean_abs_r;
  logic signed [PCT_W-1:0]     mean_pct_r;

  // output register
  logic                    out_valid_r;
  logic [TRIALS_W-1:0]     o_trials_r;
  logic [VAL_W-1:0]        o_mean_abs_r, o_max_abs_r, o_min_abs_r;
  logic signed [PCT_W-1:0] o_mean_pct_r, o_max_pct_r, o_min_pct_r;
  logic                    o_zref_r;

  // input side
  logic signed [VAL_W:0] diff_in;
  logic [VAL_W:0]        diff_abs;
  logic [VAL_W-1:0]      err_in;
  logic [VAL_W-1:0]      den_in;

  assign diff_in  = {in_ch.correct_value[VAL_W-1], in_ch.correct_value}
                  - {in_ch.measured_value[VAL_W-1], in_ch.measured_value};
  assign diff_abs = diff_in[VAL_W] ? (~diff_in + 1'b1) : diff_in;
  assign err_in   = diff_abs[VAL_W-1:0];
  assign den_in   = in_ch.correct_value[VAL_W-1] ? (~in_ch.correct_value + 1'b1)
                                                 : in_ch.correct_value;

  // divider operand selection
  logic [DVD_W-1:0] pct_mag;
  logic [DVD_W-1:0] dividend;
  logic [DVD_W-1:0] dvd_hi;
  logic [DVD_W-1:0] dvd_load;
  logic [DVR_W-1:0] divisor;
  logic [QCNT_W-1:0] q_bits;
  logic [QW_PCT-1:0] q_sat;
  logic              div_sat;

  assign pct_mag = pct_sum_r[PCT_SUM_W-1] ? (~pct_sum_r + 1'b1) : pct_sum_r;

  always_comb begin
    dividend = '0;
    divisor  = '0;
    dvd_hi   = '0;
    dvd_load = '0;
    q_bits   = QCNT_W'(QW_PCT);
    q_sat    = '1;
    unique case (op_r)
      OP_RATIO: begin
        dividend = DVD_W'(err_r) << FRAC_BITS;
        divisor  = DVR_W'(den_r);
        dvd_hi   = dividend >> QW_PCT;
        dvd_load = dividend << (DVD_W - QW_PCT);
        q_bits   = QCNT_W'(QW_PCT);
        q_sat    = '1;
      end
      OP_MABS: begin
        dividend = DVD_W'(abs_sum_r);
        divisor  = DVR_W'(count_r);
        dvd_hi   = dividend >> QW_ABS;
        dvd_load = dividend << (DVD_W - QW_ABS);
        q_bits   = QCNT_W'(QW_ABS);
        q_sat    = QW_PCT'({QW_ABS{1'b1}});
      end
      OP_MPCT: begin
        dividend = pct_mag;
        divisor  = DVR_W'(count_r);
        dvd_hi   = dividend >> QW_PCT;
        dvd_load = dividend << (DVD_W - QW_PCT);
        q_bits   = QCNT_W'(QW_PCT);
        q_sat    = '1;
      end
      default: begin
        dividend = '0;
      end
    endcase
  end

  assign div_sat = dvd_hi >= DVD_W'(divisor);

  // one restoring step
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] rem_sub;
  logic          q_bit;

  assign rem_sh  = {rem_r[RW-2:0], dvd_r[DVD_W-1]};
  assign q_bit   = rem_sh >= RW'(divisor);
  assign rem_sub = rem_sh - RW'(divisor);

  logic signed [PCT_W-1:0] q_pos;
  assign q_pos = signed'(PCT_W'(q_r));

  // accumulators
  logic                        first;
  logic                        cnt_full;
  logic [ABS_SUM_W:0]          abs_add;
  logic signed [PCT_SUM_W:0]   pct_add;

  assign first    = count_r == '0;
  assign cnt_full = count_r == '1;
  assign abs_add  = {1'b0, abs_sum_r} + (ABS_SUM_W + 1)'(err_r);
  assign pct_add  = {pct_sum_r[PCT_SUM_W-1], pct_sum_r}
                  + {{(PCT_SUM_W + 1 - PCT_W){pct_r[PCT_W-1]}}, pct_r};

  logic [TRW-1:0]      count_ext;
  logic [TRIALS_W-1:0] trials_sat;
  assign count_ext  = TRW'(count_r);
  assign trials_sat = (count_ext > TRW'({TRIALS_W{1'b1}})) ? '1 : count_ext[TRIALS_W-1:0];

  // control outputs
  always_comb begin
    in_ready = state_r == S_IDLE;
    in_acc   = in_ready && in_ch.valid;
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.req_type)
            state_nxt = S_DONE;
          else if (in_ch.correct_value == '0)
            state_nxt = S_STATS;
          else
            state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = div_sat ? S_POST : S_DIV;
      S_DIV:  if (cnt_r == QCNT_W'(1)) state_nxt = S_POST;
      S_POST: begin
        unique case (op_r)
          OP_RATIO: state_nxt = S_STATS;
          OP_MABS:  state_nxt = S_LOAD;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_STATS: state_nxt = S_PSUM;
      S_PSUM:  state_nxt = S_LOAD;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      abs_sum_r   <= '0;
      pct_sum_r   <= '0;
      abs_max_r   <= '0;
      abs_min_r   <= '0;
      pct_max_r   <= '0;
      pct_min_r   <= '0;
      mean_abs_r  <= '0;
      mean_pct_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;

      if (in_acc && in_ch.req_type) begin
        count_r    <= '0;
        abs_sum_r  <= '0;
        pct_sum_r  <= '0;
        abs_max_r  <= '0;
        abs_min_r  <= '0;
        pct_max_r  <= '0;
        pct_min_r  <= '0;
        mean_abs_r <= '0;
        mean_pct_r <= '0;
      end

      if (state_r == S_STATS) begin
        if (first || err_r > abs_max_r) abs_max_r <= err_r;
        if (first || err_r < abs_min_r) abs_min_r <= err_r;
        if (first || pct_r > pct_max_r) pct_max_r <= pct_r;
        if (first || pct_r < pct_min_r) pct_min_r <= pct_r;
        if (!cnt_full)
          abs_sum_r <= abs_add[ABS_SUM_W] ? '1 : abs_add[ABS_SUM_W-1:0];
      end

      if (state_r == S_PSUM && sum_en_r) begin
        count_r <= count_r + 1'b1;
        if (pct_add[PCT_SUM_W] != pct_add[PCT_SUM_W-1])
          pct_sum_r <= pct_add[PCT_SUM_W] ? {1'b1, {(PCT_SUM_W-1){1'b0}}}
                                          : {1'b0, {(PCT_SUM_W-1){1'b1}}};
        else
          pct_sum_r <= pct_add[PCT_SUM_W-1:0];
      end

      if (state_r == S_POST) begin
        unique case (op_r)
          OP_MABS: mean_abs_r <= q_r[VAL_W-1:0];
          OP_MPCT: mean_pct_r <= pct_sum_r[PCT_SUM_W-1] ? -q_pos : q_pos;
          default: ;
        endcase
      end
    end
  end

  // datapath and output payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r  <= err_in;
      den_r  <= den_in;
      neg_r  <= in_ch.correct_value[VAL_W-1];
      zref_r <= !in_ch.req_type && (in_ch.correct_value == '0);
      op_r   <= OP_RATIO;
      pct_r  <= signed'(RATIO_MAX);
    end

    unique case (state_r)
      S_LOAD: begin
        rem_r <= RW'(dvd_hi);
        dvd_r <= dvd_load;
        cnt_r <= q_bits;
        q_r   <= q_sat;
      end
      S_DIV: begin
        rem_r <= q_bit ? rem_sub : rem_sh;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - 1'b1;
        q_r   <= {q_r[QW_PCT-2:0], q_bit};
      end
      S_POST: begin
        unique case (op_r)
          OP_RATIO: pct_r <= neg_r ? -q_pos : q_pos;
          OP_MABS:  op_r  <= OP_MPCT;
          default:  ;
        endcase
      end
      S_STATS: sum_en_r <= !cnt_full;
      S_PSUM:  op_r     <= OP_MABS;
      default: ;
    endcase

    if (out_load) begin
      o_trials_r   <= trials_sat;
      o_mean_abs_r <= mean_abs_r;
      o_max_abs_r  <= first ? '0 : abs_max_r;
      o_min_abs_r  <= first ? '0 : abs_min_r;
      o_mean_pct_r <= mean_pct_r;
      o_max_pct_r  <= first ? '0 : pct_max_r;
      o_min_pct_r  <= first ? '0 : pct_min_r;
      o_zref_r     <= zref_r;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.trials       = o_trials_r;
  assign out_ch.mean_abs_err = o_mean_abs_r;
  assign out_ch.max_abs_err  = o_max_abs_r;
  assign out_ch.min_abs_err  = o_min_abs_r;
  assign out_ch.mean_pct_err = o_mean_pct_r;
  assign out_ch.max_pct_err  = o_max_pct_r;
  assign out_ch.min_pct_err  = o_min_pct_r;
  assign out_ch.zero_ref     = o_zref_r;

  `APES_ASSERT(a_clear_zeroes_count, in_acc && in_ch.req_type |=> count_r == '0, "clear left count")
  `APES_ASSERT(a_div_count_live, state_r == S_DIV |-> cnt_r != '0, "divider step count ran out")
  `APES_ASSERT(a_mean_below_max, out_valid_r |-> o_mean_abs_r <= o_max_abs_r, "mean above max")
  `APES_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "not idle after reset")

endmodule
